// ===== rtl/kmp_pkg.sv =====
package kmp_pkg;

   // Longest pattern held, and the widths that follow from it
   localparam int MAX_PATTERN = 64;
   localparam int POS_W       = $clog2(MAX_PATTERN + 1);
   localparam int ADDR_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   localparam int SYM_W       = 8;
   localparam int COUNT_W     = 16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Item kinds carried on tuser
   localparam logic KIND_PATTERN = 1'b0;
   localparam logic KIND_TEXT    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_WAIT
   } state_type;

   // Result of one compare-and-fall-back step
   typedef struct packed {
      logic             fin;
      logic [POS_W-1:0] next;
   } step_res_type;

endpackage

// ===== rtl/kmp_ram.sv =====
module kmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/kmp_step.sv =====
module kmp_step (
   input  logic [kmp_pkg::POS_W-1:0]   cur,
   input  logic [kmp_pkg::SYM_W-1:0]   sym,
   input  logic [kmp_pkg::SYM_W-1:0]   pat_data,
   input  logic [kmp_pkg::POS_W-1:0]   fail_data,
   output kmp_pkg::step_res_type       res
);

   // Compare the stored byte; advance on a hit, fall back on a miss
   always_comb begin
      res.fin  = 1'b1;
      res.next = '0;
      if (pat_data == sym) begin
         res.next = cur + kmp_pkg::POS_W'(1);
      end else if (cur != '0) begin
         res.fin  = 1'b0;
         res.next = fail_data;
      end
   end

endmodule

// ===== rtl/kmp_pattern_occurrence_counter.sv =====
// Knuth-Morris-Pratt occurrence counter. Pattern bytes (tuser = 0) are appended
// one at a time, up to 64, and each append computes its failure-table entry;
// tdata[8] set on a pattern byte starts a new pattern. Text bytes (tuser = 1)
// each give one result: tdata[0] says a full occurrence ends on that byte,
// tdata[16:1] is the saturating count of overlapping occurrences in the current
// text, and tlast echoes the input tlast. tdata[8] on a text byte, or any
// pattern byte, clears the count and the match position. The block works on
// one item at a time through a single compare/fall-back unit and two registered
// memories: each comparison is a memory read, then a compare. A pattern byte
// needs no comparison when it is the first or is dropped, and a text byte needs
// none with an empty pattern. A text byte may also wait for the result register
// to drain. Over a long text the comparisons average at most about two per byte.
module kmp_pattern_occurrence_counter (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,  // [7:0] symbol, [8] first, [15:9] zero
   input  logic         req_tuser,  // kind
   input  logic         req_tlast,  // end_of_text
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,  // [0] match_here, [16:1] match_count, [23:17] zero
   output logic         rsp_tlast   // last
);

   localparam int PW = kmp_pkg::POS_W;
   localparam int AW = kmp_pkg::ADDR_W;
   localparam int SW = kmp_pkg::SYM_W;
   localparam int CW = kmp_pkg::COUNT_W;

   kmp_pkg::state_type state_ff, state_in;
   logic [PW-1:0] len_ff, len_in;
   logic [PW-1:0] border_ff, border_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [PW-1:0] cur_ff, cur_in;
   logic [SW-1:0] sym_ff, sym_in;
   logic          mode_ff, mode_in;
   logic          eot_ff, eot_in;
   logic          hit_ff, hit_in;
   logic          rsp_hit_ff, rsp_hit_in;
   logic [CW-1:0] rsp_count_ff, rsp_count_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          pat_we;
   logic [AW-1:0] pat_waddr;
   logic [SW-1:0] pat_rdata;
   logic          fail_we;
   logic [AW-1:0] fail_waddr;
   logic [PW-1:0] fail_wdata;
   logic [PW-1:0] fail_rdata;
   logic [PW-1:0] cur_dec;

   logic [SW-1:0] req_symbol;
   logic          req_first;
   logic          req_fire;
   logic [PW-1:0] len_e, border_e;

   kmp_pkg::step_res_type step;

   assign req_symbol = req_tdata[SW-1:0];
   assign req_first  = req_tdata[SW];
   assign req_tready = (state_ff == kmp_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign cur_dec    = cur_ff - PW'(1);

   // Pattern bytes read at the current position, failure entries at the one before it
   kmp_ram #(.WIDTH(SW), .DEPTH(kmp_pkg::MAX_PATTERN)) u_pat_ram (
      .clock   (clock),
      .wr_en   (pat_we),
      .wr_addr (pat_waddr),
      .wr_data (req_symbol),
      .rd_addr (cur_ff[AW-1:0]),
      .rd_data (pat_rdata)
   );

   kmp_ram #(.WIDTH(PW), .DEPTH(kmp_pkg::MAX_PATTERN)) u_fail_ram (
      .clock   (clock),
      .wr_en   (fail_we),
      .wr_addr (fail_waddr),
      .wr_data (fail_wdata),
      .rd_addr (cur_dec[AW-1:0]),
      .rd_data (fail_rdata)
   );

   kmp_step u_step (
      .cur       (cur_ff),
      .sym       (sym_ff),
      .pat_data  (pat_rdata),
      .fail_data (fail_rdata),
      .res       (step)
   );

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kmp_pkg::ST_IDLE;
         len_ff       <= '0;
         border_ff    <= '0;
         pos_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         border_ff    <= border_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold item and result payload
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      sym_ff       <= sym_in;
      mode_ff      <= mode_in;
      eot_ff       <= eot_in;
      hit_ff       <= hit_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign len_e    = req_first ? '0 : len_ff;
   assign border_e = req_first ? '0 : border_ff;

   // Sequence accept, compare loop and result hand-off
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      border_in    = border_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cur_in       = cur_ff;
      sym_in       = sym_ff;
      mode_in      = mode_ff;
      eot_in       = eot_ff;
      hit_in       = hit_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      pat_we       = 1'b0;
      pat_waddr    = len_e[AW-1:0];
      fail_we      = 1'b0;
      fail_waddr   = len_ff[AW-1:0];
      fail_wdata   = step.next;

      unique case (state_ff)
         kmp_pkg::ST_IDLE: begin
            if (req_fire) begin
               sym_in  = req_symbol;
               mode_in = req_tuser;
               eot_in  = req_tlast;
               if (req_tuser == kmp_pkg::KIND_PATTERN) begin
                  pos_in    = '0;
                  count_in  = '0;
                  len_in    = len_e;
                  border_in = border_e;
                  if (len_e < PW'(kmp_pkg::MAX_PATTERN)) begin
                     pat_we = 1'b1;
                     if (len_e == '0) begin
                        // First byte: border is zero, no search
                        fail_we    = 1'b1;
                        fail_waddr = '0;
                        fail_wdata = '0;
                        border_in  = '0;
                        len_in     = PW'(1);
                     end else begin
                        cur_in   = border_e;
                        state_in = kmp_pkg::ST_READ;
                     end
                  end
               end else begin
                  pos_in   = req_first ? '0 : pos_ff;
                  count_in = req_first ? '0 : count_ff;
                  if (len_ff == '0) begin
                     // Empty pattern never matches
                     hit_in   = 1'b0;
                     state_in = kmp_pkg::ST_WAIT;
                  end else begin
                     cur_in   = req_first ? '0 : pos_ff;
                     state_in = kmp_pkg::ST_READ;
                  end
               end
            end
         end

         kmp_pkg::ST_READ: begin
            state_in = kmp_pkg::ST_EVAL;
         end

         kmp_pkg::ST_EVAL: begin
            if (!step.fin) begin
               cur_in   = step.next;
               state_in = kmp_pkg::ST_READ;
            end else if (mode_ff == kmp_pkg::KIND_PATTERN) begin
               // Store the new border and grow the pattern
               fail_we   = 1'b1;
               border_in = step.next;
               len_in    = len_ff + PW'(1);
               state_in  = kmp_pkg::ST_IDLE;
            end else begin
               if (step.next >= len_ff) begin
                  pos_in = border_ff;
                  hit_in = 1'b1;
                  if (count_ff != kmp_pkg::COUNT_MAX) begin
                     count_in = count_ff + CW'(1);
                  end
               end else begin
                  pos_in = step.next;
                  hit_in = 1'b0;
               end
               state_in = kmp_pkg::ST_WAIT;
            end
         end

         kmp_pkg::ST_WAIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_count_in = count_ff;
               rsp_last_in  = eot_ff;
               state_in     = kmp_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = kmp_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_count_ff, rsp_hit_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Match position always lies inside the pattern
   a_pos_in_pattern: assert property (@(posedge clock) disable iff (reset)
      (pos_ff == '0) || (pos_ff < len_ff))
      else $error("match position outside pattern");

   // Border of the stored pattern is a proper border
   a_border_proper: assert property (@(posedge clock) disable iff (reset)
      (border_ff == '0) || (border_ff < len_ff))
      else $error("border not shorter than pattern");

   // Pattern never grows past the store
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= PW'(kmp_pkg::MAX_PATTERN))
      else $error("pattern length beyond store depth");

   // A reported occurrence comes with a nonzero count
   a_hit_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> (rsp_count_ff != '0))
      else $error("occurrence reported with zero count");

endmodule
